/* rtl/q2e_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types and constants of the quaternion to Euler converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int TERM_W  = 36;  // Q2.28 terms, doubled sums of Q1.14 products
  localparam int CORD_W  = 40;  // CORDIC x/y with gain headroom
  localparam int ANG_W   = 30;  // angles in 2^-24 rad
  localparam int MUL_W   = 30;  // shared multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int REM_W   = 57;  // square root radicand, up to 2^56
  localparam int CNT_W   = 5;
  localparam int MAX_STEPS   = 24;
  localparam int SQRT_ITERS  = 29;

  localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd268435456);
  localparam logic signed [ANG_W-1:0]  PI_A24  = ANG_W'(64'sd52707179);
  localparam logic signed [18:0] LIM_FULL = 19'sd12868;
  localparam logic signed [18:0] LIM_HALF = 19'sd6434;
  localparam logic signed [15:0] TURN_MAX = 16'sd32767;

  localparam logic [23:0] ATAN_TAB [MAX_STEPS] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
    24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384,
    24'd8192, 24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
  };

  typedef enum logic [3:0] {
    OP_YY, OP_ZZ, OP_XY, OP_WZ, OP_WY, OP_XZ, OP_YZ, OP_WX, OP_XX,
    OP_T2SQ, OP_TURN
  } mul_op_e;

  typedef enum logic [1:0] {
    ANG_ROLL, ANG_PITCH, ANG_YAW
  } angle_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD, ST_DRAIN, ST_CLAMP, ST_SQ_MUL, ST_SQ_LOAD, ST_SQRT,
    ST_CINIT, ST_CITER, ST_CROUND, ST_UNWRAP, ST_TURN_MUL, ST_TURN_ACC,
    ST_DONE
  } state_e;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_TURN_STEP = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    mul_op_e          mul_op;
    logic             clamp;
    logic             sqrt_step;
    logic             cordic_init;
    logic             cordic_step;
    logic [CNT_W-1:0] step_idx;
    angle_e           angle;
    logic             round_store;
    logic             unwrap;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/q2e_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e stream interfaces
// Quaternion input channel and Euler result channel, valid/ready.
// ----------------------------------------------------------------------------
interface q2e_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] roll_angle;
  logic signed [13:0] pitch_angle;
  logic signed [14:0] wrapped_yaw;
  logic signed [15:0] turns;
  logic signed [30:0] unwrapped_yaw;

  modport source (output valid, roll_angle, pitch_angle, wrapped_yaw, turns,
                  unwrapped_yaw, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, wrapped_yaw, turns,
                  unwrapped_yaw, output ready);
endinterface

/* rtl/q2e_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_ctrl
// Sequencer: steps the shared multiplier, square root and CORDIC unit.
// ----------------------------------------------------------------------------
module q2e_ctrl #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output q2e_pkg::dp_cmd_t    cmd_o,
  input  q2e_pkg::dp_status_t status_i
);

  localparam int STEPS = (CORDIC_STEPS > q2e_pkg::MAX_STEPS) ?
                         q2e_pkg::MAX_STEPS : CORDIC_STEPS;
  localparam logic [q2e_pkg::CNT_W-1:0] LAST_STEP = q2e_pkg::CNT_W'(STEPS - 1);
  localparam logic [q2e_pkg::CNT_W-1:0] LAST_SQRT =
    q2e_pkg::CNT_W'(q2e_pkg::SQRT_ITERS - 1);
  localparam logic [q2e_pkg::CNT_W-1:0] LAST_PROD =
    q2e_pkg::CNT_W'(q2e_pkg::OP_XX);

  q2e_pkg::state_e             state_q, state_d;
  q2e_pkg::angle_e             angle_q, angle_d;
  logic [q2e_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= q2e_pkg::ST_IDLE;
      angle_q <= q2e_pkg::ANG_ROLL;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      angle_q <= angle_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    angle_d    = angle_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o          = '0;
    cmd_o.mul_op   = q2e_pkg::mul_op_e'(cnt_q[3:0]);
    cmd_o.angle    = angle_q;
    cmd_o.step_idx = cnt_q;
    case (state_q)
      q2e_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = q2e_pkg::ST_PROD;
        end
      end
      q2e_pkg::ST_PROD: begin
        cmd_o.mul_en = 1'b1;
        if (cnt_q == LAST_PROD) begin
          state_d = q2e_pkg::ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      q2e_pkg::ST_DRAIN: state_d = q2e_pkg::ST_CLAMP;
      q2e_pkg::ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = q2e_pkg::ST_SQ_MUL;
      end
      q2e_pkg::ST_SQ_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = q2e_pkg::OP_T2SQ;
        state_d      = q2e_pkg::ST_SQ_LOAD;
      end
      q2e_pkg::ST_SQ_LOAD: begin
        cnt_d   = '0;
        state_d = q2e_pkg::ST_SQRT;
      end
      q2e_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == LAST_SQRT) begin
          angle_d = q2e_pkg::ANG_ROLL;
          state_d = q2e_pkg::ST_CINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      q2e_pkg::ST_CINIT: begin
        cmd_o.cordic_init = 1'b1;
        cnt_d   = '0;
        state_d = q2e_pkg::ST_CITER;
      end
      q2e_pkg::ST_CITER: begin
        cmd_o.cordic_step = 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = q2e_pkg::ST_CROUND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      q2e_pkg::ST_CROUND: begin
        cmd_o.round_store = 1'b1;
        case (angle_q)
          q2e_pkg::ANG_ROLL: begin
            angle_d = q2e_pkg::ANG_PITCH;
            state_d = q2e_pkg::ST_CINIT;
          end
          q2e_pkg::ANG_PITCH: begin
            angle_d = q2e_pkg::ANG_YAW;
            state_d = q2e_pkg::ST_CINIT;
          end
          default: state_d = q2e_pkg::ST_UNWRAP;
        endcase
      end
      q2e_pkg::ST_UNWRAP: begin
        cmd_o.unwrap = 1'b1;
        state_d      = q2e_pkg::ST_TURN_MUL;
      end
      q2e_pkg::ST_TURN_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = q2e_pkg::OP_TURN;
        state_d      = q2e_pkg::ST_TURN_ACC;
      end
      q2e_pkg::ST_TURN_ACC: state_d = q2e_pkg::ST_DONE;
      q2e_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = q2e_pkg::ST_IDLE;
        end
      end
      default: state_d = q2e_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/q2e_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_datapath
// Terms, shared multiplier, bit-serial square root, CORDIC, unwrap, output.
// ----------------------------------------------------------------------------
module q2e_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q2e_pkg::dp_cmd_t    cmd_i,
  output q2e_pkg::dp_status_t status_o,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  input  logic [14:0]         unwrap_threshold_i,
  input  logic [14:0]         turn_step_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [14:0]  roll_angle_o,
  output logic signed [13:0]  pitch_angle_o,
  output logic signed [14:0]  wrapped_yaw_o,
  output logic signed [15:0]  turns_o,
  output logic signed [30:0]  unwrapped_yaw_o
);

  localparam int TW = q2e_pkg::TERM_W;
  localparam int CW = q2e_pkg::CORD_W;
  localparam int AW = q2e_pkg::ANG_W;
  localparam int MW = q2e_pkg::MUL_W;
  localparam int PW = q2e_pkg::PROD_W;
  localparam int RW = q2e_pkg::REM_W;

  logic signed [15:0] w_q, x_q, y_q, z_q;
  logic signed [TW-1:0] t0_q, t1_q, t2_q, t3_q, t4_q;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_q;
  logic                 prod_vld_q;
  q2e_pkg::mul_op_e     prod_op_q;
  logic signed [TW-1:0] p2;
  logic [RW-1:0]        rem_q;
  logic [RW:0]          res_q, sq_sum;
  logic [RW-1:0]        bit_q;
  logic signed [CW-1:0] cx_q, cy_q, cxs, cys;
  logic signed [AW-1:0] ang_q;
  logic                 zero_q;
  logic signed [TW-1:0] in_x, in_y;
  logic signed [AW:0]   rsum;
  logic signed [18:0]   rsh, rlim, rcl;
  logic signed [14:0]   roll_q, yaw_q;
  logic signed [13:0]   pitch_q;
  logic signed [15:0]   last_yaw_q, turn_q, yaw_ext;
  logic signed [16:0]   dn, up, thr;
  logic signed [30:0]   unw_q;
  logic                 out_valid_q;
  logic signed [14:0]   o_roll_q, o_yaw_q;
  logic signed [13:0]   o_pitch_q;
  logic signed [15:0]   o_turns_q;
  logic signed [30:0]   o_unw_q;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      q2e_pkg::OP_YY: begin mul_a = MW'(y_q); mul_b = MW'(y_q); end
      q2e_pkg::OP_ZZ: begin mul_a = MW'(z_q); mul_b = MW'(z_q); end
      q2e_pkg::OP_XY: begin mul_a = MW'(x_q); mul_b = MW'(y_q); end
      q2e_pkg::OP_WZ: begin mul_a = MW'(w_q); mul_b = MW'(z_q); end
      q2e_pkg::OP_WY: begin mul_a = MW'(w_q); mul_b = MW'(y_q); end
      q2e_pkg::OP_XZ: begin mul_a = MW'(x_q); mul_b = MW'(z_q); end
      q2e_pkg::OP_YZ: begin mul_a = MW'(y_q); mul_b = MW'(z_q); end
      q2e_pkg::OP_WX: begin mul_a = MW'(w_q); mul_b = MW'(x_q); end
      q2e_pkg::OP_XX: begin mul_a = MW'(x_q); mul_b = MW'(x_q); end
      q2e_pkg::OP_T2SQ: begin
        mul_a = t2_q[MW-1:0];
        mul_b = t2_q[MW-1:0];
      end
      q2e_pkg::OP_TURN: begin
        mul_a = MW'(turn_q);
        mul_b = $signed({{(MW-15){1'b0}}, turn_step_i});
      end
      default: ;
    endcase
  end

  assign p2     = {prod_q[TW-2:0], 1'b0};
  assign sq_sum = res_q + {1'b0, bit_q};

  // CORDIC operand select and shifted terms
  always_comb begin
    case (cmd_i.angle)
      q2e_pkg::ANG_ROLL: begin in_y = t3_q; in_x = t4_q; end
      q2e_pkg::ANG_PITCH: begin
        in_y = t2_q;
        in_x = $signed({{(TW-29){1'b0}}, res_q[28:0]});
      end
      default: begin in_y = t1_q; in_x = t0_q; end
    endcase
  end
  assign cxs = cx_q >>> cmd_i.step_idx;
  assign cys = cy_q >>> cmd_i.step_idx;

  // rounding to 2^-12 rad (roll and yaw Q2.12, pitch Q1.12) with clamp
  assign rsum = (zero_q ? '0 : (AW+1)'(ang_q)) + (AW+1)'(2048);
  assign rsh  = rsum[AW:12];
  assign rlim = (cmd_i.angle == q2e_pkg::ANG_PITCH) ? q2e_pkg::LIM_HALF :
                q2e_pkg::LIM_FULL;
  assign rcl  = (rsh > rlim) ? rlim : ((rsh < -rlim) ? -rlim : rsh);

  // unwrap compares
  assign yaw_ext = 16'(yaw_q);
  assign thr     = $signed({2'b00, unwrap_threshold_i});
  assign dn      = 17'(last_yaw_q) - 17'(yaw_ext);
  assign up      = 17'(yaw_ext) - 17'(last_yaw_q);

  // payload registers of the computation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q  <= quat_w_i;
      x_q  <= quat_x_i;
      y_q  <= quat_y_i;
      z_q  <= quat_z_i;
      t0_q <= q2e_pkg::ONE_Q28;
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= q2e_pkg::ONE_Q28;
    end
    if (cmd_i.mul_en) begin
      prod_q    <= mul_a * mul_b;
      prod_op_q <= cmd_i.mul_op;
    end
    // accumulate the registered product
    if (prod_vld_q) begin
      case (prod_op_q)
        q2e_pkg::OP_YY: begin t0_q <= t0_q - p2; t4_q <= t4_q - p2; end
        q2e_pkg::OP_ZZ: t0_q <= t0_q - p2;
        q2e_pkg::OP_XY: t1_q <= t1_q + p2;
        q2e_pkg::OP_WZ: t1_q <= t1_q + p2;
        q2e_pkg::OP_WY: t2_q <= t2_q + p2;
        q2e_pkg::OP_XZ: t2_q <= t2_q - p2;
        q2e_pkg::OP_YZ: t3_q <= t3_q + p2;
        q2e_pkg::OP_WX: t3_q <= t3_q + p2;
        q2e_pkg::OP_XX: t4_q <= t4_q - p2;
        q2e_pkg::OP_T2SQ: begin
          rem_q <= {1'b1, {(RW-1){1'b0}}} - prod_q[RW-1:0];
          res_q <= '0;
          bit_q <= {1'b1, {(RW-1){1'b0}}};
        end
        q2e_pkg::OP_TURN: unw_q <= prod_q[30:0] + 31'(yaw_q);
        default: ;
      endcase
    end
    if (cmd_i.clamp) begin
      if (t2_q > q2e_pkg::ONE_Q28) begin
        t2_q <= q2e_pkg::ONE_Q28;
      end else if (t2_q < -q2e_pkg::ONE_Q28) begin
        t2_q <= -q2e_pkg::ONE_Q28;
      end
    end
    // one result bit of the square root
    if (cmd_i.sqrt_step) begin
      if ({1'b0, rem_q} >= sq_sum) begin
        rem_q <= rem_q - sq_sum[RW-1:0];
        res_q <= (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    // CORDIC vectoring, left half-plane folded first
    if (cmd_i.cordic_init) begin
      zero_q <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        ang_q <= (in_y >= 0) ? q2e_pkg::PI_A24 : -q2e_pkg::PI_A24;
        cx_q  <= -CW'(in_x);
        cy_q  <= -CW'(in_y);
      end else begin
        ang_q <= '0;
        cx_q  <= CW'(in_x);
        cy_q  <= CW'(in_y);
      end
    end
    if (cmd_i.cordic_step) begin
      if (cy_q > 0) begin
        cx_q  <= cx_q + cys;
        cy_q  <= cy_q - cxs;
        ang_q <= ang_q + AW'(q2e_pkg::ATAN_TAB[cmd_i.step_idx]);
      end else begin
        cx_q  <= cx_q - cys;
        cy_q  <= cy_q + cxs;
        ang_q <= ang_q - AW'(q2e_pkg::ATAN_TAB[cmd_i.step_idx]);
      end
    end
    if (cmd_i.round_store) begin
      case (cmd_i.angle)
        q2e_pkg::ANG_ROLL:  roll_q  <= rcl[14:0];
        q2e_pkg::ANG_PITCH: pitch_q <= rcl[13:0];
        default:            yaw_q   <= rcl[14:0];
      endcase
    end
    if (cmd_i.out_load) begin
      o_roll_q  <= roll_q;
      o_pitch_q <= pitch_q;
      o_yaw_q   <= yaw_q;
      o_turns_q <= turn_q;
      o_unw_q   <= unw_q;
    end
  end

  // control and state: product valid, yaw history, turn count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      last_yaw_q  <= '0;
      turn_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
      if (cmd_i.unwrap) begin
        if (dn > thr) begin
          if (turn_q < q2e_pkg::TURN_MAX) turn_q <= turn_q + 16'sd1;
        end else if (up > thr) begin
          if (turn_q > -q2e_pkg::TURN_MAX) turn_q <= turn_q - 16'sd1;
        end
        last_yaw_q <= yaw_ext;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign roll_angle_o    = o_roll_q;
  assign pitch_angle_o   = o_pitch_q;
  assign wrapped_yaw_o   = o_yaw_q;
  assign turns_o         = o_turns_q;
  assign unwrapped_yaw_o = o_unw_q;

endmodule

/* rtl/quaternion_to_euler_yaw_unwrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_yaw_unwrap
// Quaternion to ZYX roll/pitch/yaw with yaw turn counting and unwrapping.
// ----------------------------------------------------------------------------
// Sequence: term products on the shared multiplier, clamp of t2, its square,
//   bit-serial square root, one CORDIC pass per angle, unwrap, turn scaling.
// A new quaternion is taken only once the last result is in the output
//   register; the square root and the shared CORDIC unit (three angles, one
//   micro-rotation a cycle) set the pace; a full output register stalls it.
// A finished result waits in the output register while the next is taken.
// Reset clears the yaw history, the turn count and loads the default
//   threshold and turn step; no clearing pass is needed.
module quaternion_to_euler_yaw_unwrap #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  q2e_quat_if.sink     in_if,
  q2e_euler_if.source  out_if,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  q2e_pkg::dp_cmd_t    cmd;
  q2e_pkg::dp_status_t status;
  logic [14:0]         thr_q, step_q;
  logic                in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 15'd24986;
      step_q <= 15'd25641;
    end else if (psel && penable && pwrite) begin
      case (q2e_pkg::reg_idx_e'(paddr[2]))
        q2e_pkg::REG_THRESHOLD: thr_q  <= pwdata[14:0];
        q2e_pkg::REG_TURN_STEP: step_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (q2e_pkg::reg_idx_e'(paddr[2]) == q2e_pkg::REG_TURN_STEP) ?
                  {17'd0, step_q} : {17'd0, thr_q};

  q2e_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  assign in_if.ready = in_ready;

  q2e_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .quat_w_i           (in_if.quat_w),
    .quat_x_i           (in_if.quat_x),
    .quat_y_i           (in_if.quat_y),
    .quat_z_i           (in_if.quat_z),
    .unwrap_threshold_i (thr_q),
    .turn_step_i        (step_q),
    .out_valid_o        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .roll_angle_o       (out_if.roll_angle),
    .pitch_angle_o      (out_if.pitch_angle),
    .wrapped_yaw_o      (out_if.wrapped_yaw),
    .turns_o            (out_if.turns),
    .unwrapped_yaw_o    (out_if.unwrapped_yaw)
  );

endmodule

/* bench/tb_quaternion_to_euler_yaw_unwrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_yaw_unwrap
// Self-checking bench for the quaternion to Euler converter. A bit-true
// predictor (CORDIC atan2, integer square root, yaw turn counting) works out
// each result; a monitor compares every output transaction in order.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_yaw_unwrap;

  localparam int STEPS = 14;
  localparam longint ONE28 = 64'sd268435456;
  localparam longint PI24  = 64'sd52707179;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
    logic signed [15:0] turns;
    logic signed [30:0] unw;
  } euler_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  q2e_quat_if  quat_bus ();
  q2e_euler_if euler_bus ();

  quaternion_to_euler_yaw_unwrap #(.CORDIC_STEPS(STEPS)) DUT (
    .clk_i, .rst_ni, .in_if(quat_bus.sink), .out_if(euler_bus.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // Predictor state and configuration copy
  int unsigned thr_q12 = 24986;
  int unsigned step_q12 = 25641;
  int hist_yaw = 0;
  int turn_cnt = 0;

  quat_t  pending_quats[$];
  euler_t euler_due[$];
  int     errors = 0;
  bit     hold_sink = 1'b0;
  bit     in_taken = 1'b0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_atan2(longint yv, longint xv);
    longint base, ang, xs, ys;
    longint tab [24];
    tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
            131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
            128, 64, 32, 16, 8, 4, 2};
    base = 0;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      base = (yv >= 0) ? PI24 : -PI24;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < (STEPS > 24 ? 24 : STEPS); i++) begin
      xs = asr(xv, i);
      ys = asr(yv, i);
      if (yv > 0) begin
        xv += ys; yv -= xs; ang += tab[i];
      end else begin
        xv -= ys; yv += xs; ang -= tab[i];
      end
    end
    return base + ang;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic int round_q12(longint a, int lim);
    longint r;
    r = asr(a + 2048, 12);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return int'(r);
  endfunction

  // Works out the Euler result of one quaternion and advances the yaw history
  function automatic euler_t euler_of(quat_t q);
    longint w, x, y, z, t0, t1, t2, t3, t4, cp;
    int r, p, yw;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    t0 = ONE28 - 2 * (y * y + z * z);
    t1 = 2 * (x * y + w * z);
    t2 = -2 * (x * z - w * y);
    t3 = 2 * (y * z + w * x);
    t4 = ONE28 - 2 * (x * x + y * y);
    if (t2 > ONE28) t2 = ONE28;
    if (t2 < -ONE28) t2 = -ONE28;
    cp = int_sqrt((64'd1 << 56) - longint'(t2 * t2));
    r  = round_q12(cordic_atan2(t3, t4), 12868);
    p  = round_q12(cordic_atan2(t2, cp), 6434);
    yw = round_q12(cordic_atan2(t1, t0), 12868);
    if (hist_yaw - yw > int'(thr_q12)) begin
      if (turn_cnt < 32767) turn_cnt++;
    end else if (yw - hist_yaw > int'(thr_q12)) begin
      if (turn_cnt > -32767) turn_cnt--;
    end
    hist_yaw = yw;
    e.roll  = r[14:0];
    e.pitch = p[13:0];
    e.yaw   = yw[14:0];
    e.turns = turn_cnt[15:0];
    e.unw   = 31'(longint'(turn_cnt) * longint'(step_q12) + yw);
    return e;
  endfunction

  // Input handshake seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && quat_bus.valid && quat_bus.ready;
  end

  // Driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  initial begin
    quat_bus.valid = 1'b0;
    {quat_bus.quat_w, quat_bus.quat_x, quat_bus.quat_y, quat_bus.quat_z} = '0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        euler_due.push_back(euler_of(pending_quats.pop_front()));
        burst_left--;
      end
      if (quat_bus.valid && !in_taken) begin
        // still offering the same transaction
      end else if (pending_quats.size() == 0) begin
        quat_bus.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        quat_bus.valid <= 1'b0;
      end else begin
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
        end
        quat_bus.valid  <= 1'b1;
        quat_bus.quat_w <= pending_quats[0].w;
        quat_bus.quat_x <= pending_quats[0].x;
        quat_bus.quat_y <= pending_quats[0].y;
        quat_bus.quat_z <= pending_quats[0].z;
      end
    end
  end

  // Receiver stall pattern
  int stall_mode = 0;
  initial euler_bus.ready = 1'b0;
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_sink) euler_bus.ready <= 1'b0;
    else case (stall_mode)
      0: euler_bus.ready <= 1'b1;
      1: euler_bus.ready <= ($urandom_range(0, 3) != 0);
      default: euler_bus.ready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Monitor: compares each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    euler_t exp_e;
    if (rst_ni && euler_bus.valid && euler_bus.ready) begin
      if (euler_due.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_e = euler_due.pop_front();
        if (euler_bus.roll_angle !== exp_e.roll) begin
          $error("roll_angle exp %0d got %0d", exp_e.roll, euler_bus.roll_angle);
          errors++;
        end
        if (euler_bus.pitch_angle !== exp_e.pitch) begin
          $error("pitch_angle exp %0d got %0d", exp_e.pitch, euler_bus.pitch_angle);
          errors++;
        end
        if (euler_bus.wrapped_yaw !== exp_e.yaw) begin
          $error("wrapped_yaw exp %0d got %0d", exp_e.yaw, euler_bus.wrapped_yaw);
          errors++;
        end
        if (euler_bus.turns !== exp_e.turns) begin
          $error("turns exp %0d got %0d", exp_e.turns, euler_bus.turns);
          errors++;
        end
        if (euler_bus.unwrapped_yaw !== exp_e.unw) begin
          $error("unwrapped_yaw exp %0d got %0d", exp_e.unw,
                 euler_bus.unwrapped_yaw);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(q2e_pkg::reg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == q2e_pkg::REG_THRESHOLD) thr_q12 = val & 32'h7FFF;
    else step_q12 = val & 32'h7FFF;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_quats.size() != 0 || quat_bus.valid || euler_due.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_comp(bit any_pattern);
    int unsigned k;
    if (any_pattern) return 16'($urandom);
    k = $urandom_range(0, 9);
    if (k == 0) return 16'sd16384;
    if (k == 1) return -16'sd16384;
    if (k == 2) return 16'sd0;
    return 16'($urandom_range(0, 32768)) - 16'sd16384;
  endfunction

  // Yaw-only rotation: spins through the wrap point
  function automatic quat_t yaw_quat(int ang_idx);
    real a;
    quat_t q;
    a = ang_idx * 3.14159265 / 64.0;
    q.w = 16'($rtoi(16384.0 * $cos(a / 2.0)));
    q.x = 16'sd0; q.y = 16'sd0;
    q.z = 16'($rtoi(16384.0 * $sin(a / 2.0)));
    return q;
  endfunction

  task automatic add_random(int n);
    quat_t q;
    int ang, dir;
    ang = $urandom_range(0, 127);
    dir = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          ang += dir * $urandom_range(1, 20);
          q = yaw_quat(ang);
        end
        1: begin
          q.w = rand_comp(1); q.x = rand_comp(1);
          q.y = rand_comp(1); q.z = rand_comp(1);
        end
        default: begin
          q.w = rand_comp(0); q.x = rand_comp(0);
          q.y = rand_comp(0); q.z = rand_comp(0);
        end
      endcase
      pending_quats.push_back(q);
    end
  endtask

  // Limit on the run
  initial begin
    #(12ns * 1500000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    quat_t q;
    int ang;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    reg_write(q2e_pkg::REG_THRESHOLD, 32'd24986);
    reg_write(q2e_pkg::REG_TURN_STEP, 32'd25641);

    // Directed: extremes, zero vector, negative x axis, non-unit, gimbal
    q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384}; pending_quats.push_back(q);
    q = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd11585, 16'sd0, -16'sd11585, 16'sd0}; pending_quats.push_back(q);
    q = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
    pending_quats.push_back(q);
    q = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
    pending_quats.push_back(q);
    q = '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384};
    pending_quats.push_back(q);
    q = '{16'sd23170, -16'sd23170, 16'sd23170, -16'sd23170};
    pending_quats.push_back(q);
    for (ang = 0; ang < 14; ang++) pending_quats.push_back(yaw_quat(ang * 20));
    wait_drained();

    // Back-pressure: sink held off while the source keeps offering
    hold_sink = 1'b1;
    add_random(40);
    repeat (3000) @(posedge clk_i);
    hold_sink = 1'b0;
    wait_drained();

    // Extreme settings: threshold zero makes almost every change a turn
    reg_write(q2e_pkg::REG_THRESHOLD, 32'd0);
    reg_write(q2e_pkg::REG_TURN_STEP, 32'd32767);
    add_random(300);
    wait_drained();

    reg_write(q2e_pkg::REG_THRESHOLD, 32'd32767);
    reg_write(q2e_pkg::REG_TURN_STEP, 32'd0);
    add_random(250);
    wait_drained();

    reg_write(q2e_pkg::REG_THRESHOLD, 32'hFFFF_8000 | $urandom_range(6000, 20000));
    reg_write(q2e_pkg::REG_TURN_STEP, $urandom);
    add_random(350);
    wait_drained();

    reg_write(q2e_pkg::REG_THRESHOLD, 32'd24986);
    reg_write(q2e_pkg::REG_TURN_STEP, 32'd25641);
    add_random(380);
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
